/* rtl/dnd_pkg.sv */
package dnd_pkg;

  // Input item: a load writes one message byte, a decode walks one name.
  typedef struct packed {
    logic        cmd;
    logic [11:0] offset;
    logic [7:0]  byte_value;
    logic [12:0] message_length;
    logic [7:0]  name_capacity;
  } dnd_in_t;

  // Result item: up to eight name bytes, with status on the final one.
  typedef struct packed {
    logic [63:0] name_bytes;
    logic [3:0]  byte_count;
    logic        final_item;
    logic [2:0]  status;
    logic [7:0]  total_length;
  } dnd_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_COPY,
    ST_PTR,
    ST_DONE
  } dnd_state_t;

  // Command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Label type codes (top two bits of a label byte).
  localparam logic [1:0] LBL_LEN = 2'b00;
  localparam logic [1:0] LBL_PTR = 2'b11;

  // Status codes.
  localparam logic [2:0] STATUS_OK   = 3'd0;
  localparam logic [2:0] STATUS_ROOM = 3'd1;
  localparam logic [2:0] STATUS_PTR  = 3'd2;
  localparam logic [2:0] STATUS_TYPE = 3'd3;
  localparam logic [2:0] STATUS_END  = 3'd4;

  // Bytes per result and the largest name.
  localparam int unsigned CHUNK_BYTES = 8;
  localparam int unsigned NAME_MAX    = 255;

endpackage

/* rtl/dns_name_decompressor.sv */
// DNS name decompressor with a byte-wide message store.
//
// Input channel: an item transfers at a rising edge with start high and busy
// low. A load item (cmd 0) writes byte_value into the store at offset and
// leaves busy low, so the block stays ready for the next item. A decode item (cmd 1)
// walks the name at offset, following compression pointers, and holds busy high
// while it runs.
// Result channel: out_valid marks each result for exactly one cycle. Full
// results carry eight bytes; the final result carries the remaining bytes, the
// status and the total name length. The receiver cannot stall the block.
// Timing: the sequencer reads one store byte per cycle through the single read
// port. A decode copies N name bytes and follows P pointer hops. N is at most
// 255, and every hop moves strictly backward, so P stays below MSG_DEPTH. The
// final result appears in the first cycle with busy low, and a new item may
// transfer in that cycle.
// Reset clears the sequencer and the output strobe; the store keeps its
// contents and each entry must be loaded before a decode reads it.
module dns_name_decompressor #(
  parameter int MSG_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dnd_pkg::dnd_in_t  in_data,
  output logic              out_valid,
  output dnd_pkg::dnd_out_t out_data
);

  localparam int AW = $clog2(MSG_DEPTH);
  localparam int EW = $clog2(MSG_DEPTH + 1);
  localparam int CW = (EW > 14) ? EW : 14;

  dnd_pkg::dnd_state_t state_r, state_nxt;
  logic [CW-1:0]  cur_r, cur_nxt;
  logic [CW-1:0]  seg_r, seg_nxt;
  logic [CW-1:0]  msg_end_r, msg_end_nxt;
  logic [7:0]     cap_r, cap_nxt;
  logic [7:0]     n_r, n_nxt;
  logic [5:0]     rem_r, rem_nxt;
  logic [5:0]     hi_r, hi_nxt;
  logic [63:0]    chunk_r, chunk_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [2:0]     status_r, status_nxt;
  logic           out_valid_r, out_valid_nxt;
  dnd_pkg::dnd_out_t out_r, out_nxt;

  logic [7:0]     mem [MSG_DEPTH];
  logic [7:0]     rdata_r;
  logic           wr_en;
  logic           accept;
  logic           app_en;
  logic [7:0]     app_byte;
  logic [CW-1:0]  ml_ext;
  logic [CW-1:0]  room_msg;
  logic [8:0]     need;
  logic [8:0]     room_name;
  logic [CW-1:0]  target;

  assign accept = start && !busy;
  assign wr_en  = accept && (in_data.cmd == dnd_pkg::CMD_LOAD) &&
                  (CW'(in_data.offset) < CW'(MSG_DEPTH));

  // Message store: loads write, the walk reads at the next cursor so that the
  // registered data always holds the byte under the current cursor.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_data.offset)] <= in_data.byte_value;
    end
    rdata_r <= mem[AW'(cur_nxt)];
  end

  // Shared arithmetic for the label checks.
  assign ml_ext    = CW'(in_data.message_length);
  assign room_msg  = msg_end_r - cur_r;
  assign need      = {1'b0, rdata_r} + 9'd1;
  assign room_name = {1'b0, cap_r} - {1'b0, n_r};
  assign target    = CW'({hi_r, rdata_r});

  // Sequencer: walks labels and pointers one store byte per cycle.
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    seg_nxt     = seg_r;
    msg_end_nxt = msg_end_r;
    cap_nxt     = cap_r;
    rem_nxt     = rem_r;
    hi_nxt      = hi_r;
    status_nxt  = status_r;
    app_en      = 1'b0;
    app_byte    = rdata_r;
    unique case (state_r)
      dnd_pkg::ST_IDLE: begin
        if (accept && (in_data.cmd == dnd_pkg::CMD_DECODE)) begin
          cur_nxt     = CW'(in_data.offset);
          seg_nxt     = CW'(in_data.offset);
          msg_end_nxt = (ml_ext > CW'(MSG_DEPTH)) ? CW'(MSG_DEPTH) : ml_ext;
          // An 8-bit capacity never exceeds the name limit of 255.
          cap_nxt     = in_data.name_capacity;
          status_nxt  = dnd_pkg::STATUS_OK;
          state_nxt   = dnd_pkg::ST_HEAD;
        end
      end
      dnd_pkg::ST_HEAD: begin
        state_nxt = dnd_pkg::ST_DONE;
        if (cur_r >= msg_end_r) begin
          status_nxt = dnd_pkg::STATUS_END;
        end else if (rdata_r == 8'd0) begin
          if (n_r >= cap_r) begin
            status_nxt = dnd_pkg::STATUS_ROOM;
          end else begin
            app_en   = 1'b1;
            app_byte = 8'd0;
          end
        end else if (room_msg < CW'(2)) begin
          status_nxt = dnd_pkg::STATUS_END;
        end else begin
          unique case (rdata_r[7:6])
            dnd_pkg::LBL_LEN: begin
              if ((room_msg < CW'(need)) || (room_name < need)) begin
                status_nxt = dnd_pkg::STATUS_ROOM;
              end else begin
                app_en    = 1'b1;
                cur_nxt   = cur_r + CW'(1);
                rem_nxt   = rdata_r[5:0];
                state_nxt = dnd_pkg::ST_COPY;
              end
            end
            dnd_pkg::LBL_PTR: begin
              hi_nxt    = rdata_r[5:0];
              cur_nxt   = cur_r + CW'(1);
              state_nxt = dnd_pkg::ST_PTR;
            end
            default: begin
              status_nxt = dnd_pkg::STATUS_TYPE;
            end
          endcase
        end
      end
      dnd_pkg::ST_PTR: begin
        if (target >= seg_r) begin
          status_nxt = dnd_pkg::STATUS_PTR;
          state_nxt  = dnd_pkg::ST_DONE;
        end else begin
          cur_nxt   = target;
          seg_nxt   = target;
          state_nxt = dnd_pkg::ST_HEAD;
        end
      end
      dnd_pkg::ST_COPY: begin
        app_en  = 1'b1;
        cur_nxt = cur_r + CW'(1);
        rem_nxt = rem_r - 6'd1;
        if (rem_r == 6'd1) begin
          state_nxt = dnd_pkg::ST_HEAD;
        end
      end
      dnd_pkg::ST_DONE: begin
        state_nxt = dnd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dnd_pkg::ST_IDLE;
      end
    endcase
  end

  // Packer: a full chunk leaves only when the next byte arrives, so that the
  // last chunk is always sent as the final result.
  always_comb begin
    n_nxt         = n_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if ((state_r == dnd_pkg::ST_IDLE) && accept &&
        (in_data.cmd == dnd_pkg::CMD_DECODE)) begin
      n_nxt     = 8'd0;
      chunk_nxt = 64'd0;
      cnt_nxt   = 4'd0;
    end else if (app_en) begin
      n_nxt = n_r + 8'd1;
      if (cnt_r == 4'(dnd_pkg::CHUNK_BYTES)) begin
        out_valid_nxt        = 1'b1;
        out_nxt.name_bytes   = chunk_r;
        out_nxt.byte_count   = cnt_r;
        out_nxt.final_item   = 1'b0;
        out_nxt.status       = dnd_pkg::STATUS_OK;
        out_nxt.total_length = n_r;
        chunk_nxt            = {56'd0, app_byte};
        cnt_nxt              = 4'd1;
      end else begin
        chunk_nxt[{cnt_r[2:0], 3'b000} +: 8] = app_byte;
        cnt_nxt = cnt_r + 4'd1;
      end
    end else if (state_r == dnd_pkg::ST_DONE) begin
      out_valid_nxt        = 1'b1;
      out_nxt.name_bytes   = chunk_r;
      out_nxt.byte_count   = cnt_r;
      out_nxt.final_item   = 1'b1;
      out_nxt.status       = status_r;
      out_nxt.total_length = n_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dnd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    seg_r     <= seg_nxt;
    msg_end_r <= msg_end_nxt;
    cap_r     <= cap_nxt;
    n_r       <= n_nxt;
    rem_r     <= rem_nxt;
    hi_r      <= hi_nxt;
    chunk_r   <= chunk_nxt;
    cnt_r     <= cnt_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != dnd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A result that is not final is always a full chunk with clean status.
  a_nonfinal_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.final_item) |->
      (out_data.byte_count == 4'(dnd_pkg::CHUNK_BYTES)) &&
      (out_data.status == dnd_pkg::STATUS_OK))
    else $error("non-final result is not a full clean chunk");

  // A successful decode always copies the terminating zero.
  a_ok_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.final_item && (out_data.status == dnd_pkg::STATUS_OK)) |->
      (out_data.byte_count != 4'd0))
    else $error("successful decode produced no bytes");

  // A load transfer never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.cmd == dnd_pkg::CMD_LOAD)) |=> !out_valid)
    else $error("load produced a result");

  // The walk only starts after a decode transfer.
  a_busy_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_data.cmd == dnd_pkg::CMD_DECODE)))
    else $error("busy rose without a decode transfer");
`endif

endmodule

/* verif/dns_name_decompressor_tb.sv */
module dns_name_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MSG_DEPTH    = 4096;
  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_ITEMS = 170;

  // Outcome of walking one name: the copied bytes, their count and the status.
  // The unsafe flag marks a walk that would touch a store entry never loaded.
  typedef struct packed {
    logic [2047:0] bytes;
    logic [8:0]    len;
    logic [2:0]    st;
    logic          unsafe;
  } walk_t;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  dnd_pkg::dnd_in_t  in_data = '0;
  logic              out_valid;
  dnd_pkg::dnd_out_t out_data;

  // Shadow of the message store and which entries have been loaded.
  bit [7:0] msg_mem   [MSG_DEPTH];
  bit       msg_known [MSG_DEPTH];

  dnd_pkg::dnd_in_t  pending_items [$];
  dnd_pkg::dnd_out_t expected_chunks [$];
  dnd_pkg::dnd_out_t want_chunk;
  int unsigned failures     = 0;
  int unsigned cycle_count  = 0;
  int unsigned random_items = 0;
  bit          count_items  = 1'b0;
  bit          gaps_on      = 1'b1;
  int          round_no     = 0;

  // Layout of the most recently built name region.
  int rg_base;
  int rg_end;
  int rg_starts [3];
  int lbl_pos [4];

  dns_name_decompressor #(
    .MSG_DEPTH(MSG_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Follow labels and backward pointers through the shadow store.
  function automatic walk_t walk_name(input logic [11:0] start_off, input logic [12:0] mlen,
                                      input logic [7:0] room);
    walk_t       w;
    int unsigned lim, cur, seg, cap, n, need, tgt, i;
    logic [7:0]  lbl;
    bit          stop;
    w = '0;
    lim = mlen;
    if (lim > MSG_DEPTH) lim = MSG_DEPTH;
    cap = room;
    if (cap > dnd_pkg::NAME_MAX) cap = dnd_pkg::NAME_MAX;
    cur = start_off;
    seg = start_off;
    n = 0;
    w.st = dnd_pkg::STATUS_OK;
    stop = 1'b0;
    while (!stop) begin
      if (cur >= lim) begin
        w.st = dnd_pkg::STATUS_END;
        stop = 1'b1;
      end else begin
        if (!msg_known[cur]) w.unsafe = 1'b1;
        lbl = msg_mem[cur];
        if (lbl == 8'd0) begin
          // Terminator: copied only if there is still room for it.
          if (n >= cap) w.st = dnd_pkg::STATUS_ROOM;
          else n++;
          stop = 1'b1;
        end else if (lim - cur < 2) begin
          w.st = dnd_pkg::STATUS_END;
          stop = 1'b1;
        end else if (lbl[7:6] == dnd_pkg::LBL_LEN) begin
          need = 1 + lbl;
          if (lim - cur < need || cap - n < need) begin
            w.st = dnd_pkg::STATUS_ROOM;
            stop = 1'b1;
          end else begin
            for (i = 0; i < need; i++) begin
              if (!msg_known[cur + i]) w.unsafe = 1'b1;
              w.bytes[(n + i) * 8 +: 8] = msg_mem[cur + i];
            end
            n += need;
            cur += need;
          end
        end else if (lbl[7:6] == dnd_pkg::LBL_PTR) begin
          if (!msg_known[cur + 1]) w.unsafe = 1'b1;
          tgt = {lbl[5:0], msg_mem[cur + 1]};
          if (tgt >= seg) begin
            w.st = dnd_pkg::STATUS_PTR;
            stop = 1'b1;
          end else begin
            cur = tgt;
            seg = tgt;
          end
        end else begin
          w.st = dnd_pkg::STATUS_TYPE;
          stop = 1'b1;
        end
      end
    end
    w.len = 9'(n);
    return w;
  endfunction

  // Update the shadow store for a load, or queue the chunks a decode produces.
  function automatic void apply_item(input dnd_pkg::dnd_in_t it);
    walk_t             w;
    dnd_pkg::dnd_out_t c;
    int unsigned       n, chunks, k, base, cnt;
    if (it.cmd == dnd_pkg::CMD_LOAD) begin
      msg_mem[it.offset] = it.byte_value;
      msg_known[it.offset] = 1'b1;
    end else begin
      w = walk_name(it.offset, it.message_length, it.name_capacity);
      n = w.len;
      chunks = (n + dnd_pkg::CHUNK_BYTES - 1) / dnd_pkg::CHUNK_BYTES;
      if (chunks == 0) chunks = 1;
      for (k = 0; k < chunks; k++) begin
        base = k * dnd_pkg::CHUNK_BYTES;
        cnt = (n > base) ? n - base : 0;
        if (cnt > dnd_pkg::CHUNK_BYTES) cnt = dnd_pkg::CHUNK_BYTES;
        c.name_bytes   = w.bytes[base * 8 +: 64];
        c.byte_count   = 4'(cnt);
        c.final_item   = (k + 1 == chunks);
        c.status       = (k + 1 == chunks) ? w.st : dnd_pkg::STATUS_OK;
        c.total_length = 8'(base + cnt);
        expected_chunks = {expected_chunks, c};
      end
    end
  endfunction

  // Driver: on each transfer predict its results, then offer the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_item(in_data);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 7)) begin
        start   <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest expected chunk.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_chunks.size() == 0) begin
        $error("result with no expected chunk: name_bytes %h", out_data.name_bytes);
        failures++;
      end else begin
        want_chunk = expected_chunks.pop_front();
        if (out_data.name_bytes !== want_chunk.name_bytes) begin
          $error("name_bytes: expected %h, actual %h", want_chunk.name_bytes,
                 out_data.name_bytes);
          failures++;
        end
        if (out_data.byte_count !== want_chunk.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", want_chunk.byte_count,
                 out_data.byte_count);
          failures++;
        end
        if (out_data.final_item !== want_chunk.final_item) begin
          $error("final_item: expected %0d, actual %0d", want_chunk.final_item,
                 out_data.final_item);
          failures++;
        end
        if (out_data.status !== want_chunk.status) begin
          $error("status: expected %0d, actual %0d", want_chunk.status, out_data.status);
          failures++;
        end
        if (out_data.total_length !== want_chunk.total_length) begin
          $error("total_length: expected %0d, actual %0d", want_chunk.total_length,
                 out_data.total_length);
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("dns_name_decompressor test failed");
      $finish;
    end
  end

  task automatic queue_load(input int addr, input int val);
    dnd_pkg::dnd_in_t it;
    it.cmd            = dnd_pkg::CMD_LOAD;
    it.offset         = 12'(addr);
    it.byte_value     = 8'(val);
    it.message_length = 13'($urandom_range(0, 8191));
    it.name_capacity  = 8'($urandom_range(0, 255));
    pending_items = {pending_items, it};
    if (count_items) random_items++;
  endtask

  task automatic queue_decode(input int off, input int mlen, input int cap);
    dnd_pkg::dnd_in_t it;
    it.cmd            = dnd_pkg::CMD_DECODE;
    it.offset         = 12'(off);
    it.byte_value     = 8'($urandom_range(0, 255));
    it.message_length = 13'(mlen);
    it.name_capacity  = 8'(cap);
    pending_items = {pending_items, it};
    if (count_items) random_items++;
  endtask

  // Wait until every queued item has transferred and every result has come.
  task automatic settle();
    @(negedge clk);
    while (pending_items.size() != 0 || start || busy || expected_chunks.size() != 0)
      @(negedge clk);
  endtask

  // Write a region of three names: plain labels, zero or more labels plus a pointer
  // into the first name, and a pointer to the second name.
  task automatic build_region(input bit long_form);
    int p, nl, len, n2, pick, i, j;
    p = long_form ? $urandom_range(16, 3800) : $urandom_range(16, 4020);
    rg_base = p;
    nl = long_form ? 4 : $urandom_range(1, 4);
    for (i = 0; i < nl; i++) begin
      len = long_form ? ((i == 3) ? 61 : 63) : $urandom_range(1, 10);
      lbl_pos[i] = p;
      queue_load(p, len);
      p++;
      for (j = 0; j < len; j++) begin
        queue_load(p, $urandom_range(0, 255));
        p++;
      end
    end
    queue_load(p, 0);
    p++;
    rg_starts[0] = rg_base;
    rg_starts[1] = p;
    n2 = long_form ? 1 : $urandom_range(0, 2);
    for (i = 0; i < n2; i++) begin
      len = long_form ? 1 : $urandom_range(1, 6);
      queue_load(p, len);
      p++;
      for (j = 0; j < len; j++) begin
        queue_load(p, $urandom_range(0, 255));
        p++;
      end
    end
    pick = long_form ? lbl_pos[1] : lbl_pos[$urandom_range(0, nl - 1)];
    queue_load(p, {dnd_pkg::LBL_PTR, pick[13:8]});
    queue_load(p + 1, pick[7:0]);
    p += 2;
    rg_starts[2] = p;
    pick = rg_starts[1];
    queue_load(p, {dnd_pkg::LBL_PTR, pick[13:8]});
    queue_load(p + 1, pick[7:0]);
    rg_end = p + 2;
  endtask

  // Overwrite a few bytes of the region with random values.
  task automatic patch_region(input int count);
    repeat (count) queue_load($urandom_range(rg_base, rg_end - 1), $urandom_range(0, 255));
  endtask

  // Pick a decode that reads only loaded entries; a zero length is the fallback.
  task automatic queue_safe_decode();
    int    off, mlen, cap, tries, r;
    walk_t w;
    bit    found;
    found = 1'b0;
    tries = 0;
    off = 0;
    mlen = 0;
    cap = 0;
    while (!found && tries < 8) begin
      r = $urandom_range(0, 99);
      if (r < 70) off = rg_starts[$urandom_range(0, 2)];
      else if (r < 90) off = $urandom_range(rg_base, rg_end);
      else off = $urandom_range(0, 4095);
      r = $urandom_range(0, 99);
      if (r < 50) mlen = rg_end;
      else if (r < 70) mlen = rg_end + $urandom_range(0, 200);
      else if (r < 85) mlen = $urandom_range(0, 8191);
      else mlen = $urandom_range(rg_base, rg_end);
      cap = ($urandom_range(0, 99) < 60) ? 255 : $urandom_range(0, 255);
      w = walk_name(12'(off), 13'(mlen), 8'(cap));
      found = !w.unsafe;
      tries++;
    end
    if (!found) mlen = 0;
    queue_decode(off, mlen, cap);
  endtask

  task automatic decode_round(input int count);
    settle();
    repeat (count) queue_safe_decode();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: a short name at 0, a name ending in a pointer to it at 5,
    // both reserved label types, a pointer to itself, and a zero at the top.
    queue_load(0, 8'h03);
    queue_load(1, 8'h61);
    queue_load(2, 8'h62);
    queue_load(3, 8'h63);
    queue_load(4, 8'h00);
    queue_load(5, 8'h02);
    queue_load(6, 8'h78);
    queue_load(7, 8'h79);
    queue_load(8, {dnd_pkg::LBL_PTR, 6'd0});
    queue_load(9, 8'h00);
    queue_load(10, 8'h40);
    queue_load(11, 8'h80);
    queue_load(12, {dnd_pkg::LBL_PTR, 6'd0});
    queue_load(13, 8'h0c);
    queue_load(4095, 8'h00);
    settle();
    queue_decode(0, 5, 255);
    queue_decode(5, 10, 255);
    queue_decode(10, 14, 255);
    queue_decode(11, 14, 255);
    queue_decode(12, 14, 255);
    // Message ends right after a label, a label overruns it, a label in the
    // last byte, and a start offset at the end.
    queue_decode(0, 4, 255);
    queue_decode(0, 3, 255);
    queue_decode(0, 1, 255);
    queue_decode(5, 5, 255);
    // Name buffer full at the terminator, label without room, zero room.
    queue_decode(0, 5, 4);
    queue_decode(0, 8191, 3);
    queue_decode(4095, 8191, 0);
    queue_decode(4095, 4096, 255);
    settle();

    // A name of the largest size, then a name that points into it and one that points to that name.
    build_region(1'b1);
    settle();
    queue_decode(rg_starts[0], rg_end, 255);
    queue_decode(rg_starts[1], rg_end, 255);
    queue_decode(rg_starts[2], 8191, 255);
    decode_round(2);

    // Random part: fresh well-formed regions in some rounds, some corrupted bytes.
    count_items = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      gaps_on = !(round_no >= 3 && round_no < 7);
      if (round_no == 0 || $urandom_range(0, 99) < 40) begin
        build_region(1'b0);
        if ($urandom_range(0, 99) < 30) patch_region($urandom_range(1, 3));
      end else if ($urandom_range(0, 99) < 40) begin
        patch_region($urandom_range(1, 2));
      end
      if ($urandom_range(0, 99) < 15) queue_load($urandom_range(0, 4095), $urandom_range(0, 255));
      decode_round($urandom_range(3, 6));
      round_no++;
    end

    settle();
    repeat (300) @(negedge clk);
    if (failures == 0) begin
      $display("dns_name_decompressor test passed");
    end else begin
      $display("dns_name_decompressor test failed");
    end
    $finish;
  end

endmodule
